// ===== rtl/core/atlb_pkg.sv =====
// atlb_pkg: types and constants shared by the translation buffer modules
// no dependencies; imported by atlb_cell, atlb_ctrl and assoc_tlb_lru
`default_nettype none

package atlb_pkg;

   localparam int NUM_ENTRIES_DEF = 16;
   localparam int MAX_ENTRIES     = 64;
   localparam int PAGE_BITS       = 12;
   localparam int FRAME_BITS      = 8;
   localparam int STAMP_BITS      = 32;
   localparam int TOTAL_BITS      = 32;
   localparam int IDX_BITS        = $clog2(MAX_ENTRIES);

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_ADD    = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_SWEEP
   } state_type;

   typedef struct packed {
      logic                  command;
      logic [PAGE_BITS-1:0]  vpn;
      logic [FRAME_BITS-1:0] pfn;
      logic                  read_only;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [FRAME_BITS-1:0] frame_out;
      logic                  read_only_out;
      logic [TOTAL_BITS-1:0] hit_total;
      logic [TOTAL_BITS-1:0] miss_total;
      logic [TOTAL_BITS-1:0] change_total;
   } rsp_type;

   // search word handed from cell to cell
   typedef struct packed {
      logic                  hit_found;
      logic [IDX_BITS-1:0]   hit_idx;
      logic [FRAME_BITS-1:0] hit_frame;
      logic                  hit_ro;
      logic                  inv_found;
      logic [IDX_BITS-1:0]   inv_idx;
      logic                  min_set;
      logic [STAMP_BITS-1:0] min_stamp;
      logic [IDX_BITS-1:0]   min_idx;
   } sweep_type;

   // entry update sent to every cell
   typedef struct packed {
      logic                  touch;
      logic                  fill;
      logic [IDX_BITS-1:0]   idx;
      logic [STAMP_BITS-1:0] stamp;
      logic [PAGE_BITS-1:0]  page;
      logic [FRAME_BITS-1:0] frame;
      logic                  read_only;
   } upd_type;

endpackage

`default_nettype wire

// ===== rtl/core/atlb_cell.sv =====
// atlb_cell: one translation entry and its stage of the search chain
// depends on atlb_pkg
`default_nettype none

module atlb_cell import atlb_pkg::*; #(
   parameter int CELL_IDX = 0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [PAGE_BITS-1:0] key_page,
   input  wire sweep_type            sweep_prev,
   output      sweep_type            sweep_next,
   input  wire upd_type              upd
);

   localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

   logic                  valid_ff;
   logic [PAGE_BITS-1:0]  page_ff;
   logic [FRAME_BITS-1:0] frame_ff;
   logic                  ro_ff;
   logic [STAMP_BITS-1:0] stamp_ff;
   sweep_type             sweep_ff;
   sweep_type             sweep_in;
   logic                  sel;

   assign sel = upd.touch && (upd.idx == MY_IDX);

   always_comb begin
      sweep_in = sweep_prev;
      // lowest index wins, so only the first match is taken
      if (!sweep_prev.hit_found && valid_ff && (page_ff == key_page)) begin
         sweep_in.hit_found = 1'b1;
         sweep_in.hit_idx   = MY_IDX;
         sweep_in.hit_frame = frame_ff;
         sweep_in.hit_ro    = ro_ff;
      end
      if (!sweep_prev.inv_found && !valid_ff) begin
         sweep_in.inv_found = 1'b1;
         sweep_in.inv_idx   = MY_IDX;
      end
      if (!sweep_prev.min_set || (stamp_ff < sweep_prev.min_stamp)) begin
         sweep_in.min_set   = 1'b1;
         sweep_in.min_stamp = stamp_ff;
         sweep_in.min_idx   = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      sweep_ff <= sweep_in;
      if (sel && upd.fill) begin
         page_ff  <= upd.page;
         frame_ff <= upd.frame;
         ro_ff    <= upd.read_only;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         stamp_ff <= '0;
      end else if (sel) begin
         stamp_ff <= upd.stamp;
         if (upd.fill) begin
            valid_ff <= 1'b1;
         end
      end
   end

   assign sweep_next = sweep_ff;

endmodule

`default_nettype wire

// ===== rtl/core/atlb_ctrl.sv =====
// atlb_ctrl: command sequencer, stamp and statistics counters, result register
// depends on atlb_pkg
`default_nettype none

module atlb_ctrl import atlb_pkg::*; #(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire req_type              req_word,
   output      logic [PAGE_BITS-1:0] key_page,
   output      sweep_type            sweep_head,
   input  wire sweep_type            sweep_tail,
   output      upd_type              upd,
   output      logic                 rsp_valid,
   output      rsp_type              rsp_word
);

   localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_ENTRIES);

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   req_type               req_ff, req_in;
   logic [STAMP_BITS-1:0] stamp_ctr_ff, stamp_ctr_in;
   logic [TOTAL_BITS-1:0] hits_ff, hits_in;
   logic [TOTAL_BITS-1:0] misses_ff, misses_in;
   logic [TOTAL_BITS-1:0] changes_ff, changes_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   assign sweep_head = '0;
   assign key_page   = req_ff.vpn;
   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         stamp_ctr_ff <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         changes_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         stamp_ctr_ff <= stamp_ctr_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         changes_ff   <= changes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_in       = req_ff;
      stamp_ctr_in = stamp_ctr_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      changes_in   = changes_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      upd          = '0;
      upd.stamp    = stamp_ctr_ff;
      upd.page     = req_ff.vpn;
      upd.frame    = req_ff.pfn;
      upd.read_only = req_ff.read_only;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SWEEP;
               cnt_in   = '0;
               req_in   = req_word;
            end
         end
         ST_SWEEP: begin
            cnt_in = cnt_ff + 1'b1;
            // search word has passed the last cell
            if (cnt_ff == LAST_CNT) begin
               state_in      = ST_IDLE;
               cnt_in        = '0;
               rsp_valid_in  = 1'b1;
               rsp_in        = '0;
               if (req_ff.command == CMD_LOOKUP) begin
                  if (sweep_tail.hit_found) begin
                     hits_in              = hits_ff + 1'b1;
                     upd.touch            = 1'b1;
                     upd.idx              = sweep_tail.hit_idx;
                     stamp_ctr_in         = stamp_ctr_ff + 1'b1;
                     rsp_in.hit           = 1'b1;
                     rsp_in.frame_out     = sweep_tail.hit_frame;
                     rsp_in.read_only_out = sweep_tail.hit_ro;
                  end else begin
                     misses_in = misses_ff + 1'b1;
                  end
               end else begin
                  changes_in   = changes_ff + 1'b1;
                  upd.touch    = 1'b1;
                  upd.fill     = 1'b1;
                  upd.idx      = sweep_tail.inv_found ? sweep_tail.inv_idx
                                                      : sweep_tail.min_idx;
                  stamp_ctr_in = stamp_ctr_ff + 1'b1;
               end
               rsp_in.hit_total    = hits_in;
               rsp_in.miss_total   = misses_in;
               rsp_in.change_total = changes_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/assoc_tlb_lru.sv =====
// channel   ports                        direction  timing
// request   start, busy, req_word        in         taken when start high and busy low
// response  rsp_valid, rsp_word          out        one-cycle strobe, no back-pressure
//
// busy stays high after a word is taken while a search word walks the row of
// entry cells one cell per cycle, then the controller updates the chosen entry.
// the response strobe comes in the cycle busy drops; a new word may start then,
// so a new word is taken only once the last one is through.
// reset clears all entries to invalid, stamps and counters to zero.
// depends on atlb_pkg, atlb_cell, atlb_ctrl
`default_nettype none

module assoc_tlb_lru import atlb_pkg::*; #(
   parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_word,
   output      logic    rsp_valid,
   output      rsp_type rsp_word
);

   sweep_type            sweep [NUM_ENTRIES+1];
   upd_type              upd;
   logic [PAGE_BITS-1:0] key_page;

   atlb_ctrl #(
      .NUM_ENTRIES(NUM_ENTRIES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .key_page   (key_page),
      .sweep_head (sweep[0]),
      .sweep_tail (sweep[NUM_ENTRIES]),
      .upd        (upd),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word)
   );

   for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
      atlb_cell #(
         .CELL_IDX(i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .key_page   (key_page),
         .sweep_prev (sweep[i]),
         .sweep_next (sweep[i+1]),
         .upd        (upd)
      );
   end

endmodule

`default_nettype wire
